>>> sv/fmt_pkg.sv
// fmt_pkg: types, constants and helpers for the integer to ascii formatter
// no dependencies; imported by every module of the block

package fmt_pkg;

    localparam int VALUE_W      = 32;
    localparam int MAX_DIGITS   = 10;
    localparam int DIGIT_IDX_W  = $clog2(MAX_DIGITS);
    localparam int ND_W         = $clog2(MAX_DIGITS + 1);
    localparam int PAD_W        = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [PAD_W-1:0]   PAD_LIMIT = 4'd9;
    localparam logic [VALUE_W-1:0] RECIP_10  = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        OP_SDEC = 2'd0,
        OP_UDEC = 2'd1,
        OP_HEX  = 2'd2,
        OP_RSVD = 2'd3
    } fmt_op_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         opcode;
        logic [PAD_W-1:0]   pad_width;
        logic               zero_pad;
    } fmt_in_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } fmt_out_t;

    // one converted number waiting to be emitted, digits least significant first
    typedef struct packed {
        logic [MAX_DIGITS-1:0][3:0] digits;
        logic [ND_W-1:0]            nd;
        logic                       neg;
        logic [PAD_W-1:0]           pad;
        logic                       zp;
    } fmt_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fmt_q_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } fmt_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PAD,
        B_SIGN,
        B_DIGIT
    } fmt_back_state_t;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10)
        begin
            ch = CH_ZERO + {4'b0, d};
        end
        else
        begin
            ch = CH_LOWA + {4'b0, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

>>> sv/fmt_front.sv
// fmt_front: accepts an item, classifies it and extracts its digits one per cycle
// depends on fmt_pkg; feeds fmt_queue

module fmt_front
    import fmt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  fmt_in_t       in_item,
    output logic          busy,
    input  fmt_q_status_t q_status,
    output logic          push,
    output fmt_job_t      job
);

    fmt_front_state_t state_reg, state_next;

    logic [VALUE_W-1:0]           mag_reg, mag_next;
    logic                         hex_reg, hex_next;
    logic                         neg_reg, neg_next;
    logic [PAD_W-1:0]             pad_reg, pad_next;
    logic                         zp_reg, zp_next;
    logic [ND_W-1:0]              nd_reg, nd_next;
    logic [MAX_DIGITS-1:0][3:0]   digits_reg, digits_next;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   times10;
    logic [VALUE_W-1:0]   rem;
    logic [3:0]           digit;
    logic [VALUE_W-1:0]   rest;

    // divide by ten through the reciprocal, remainder by shift-add
    assign prod    = {{VALUE_W{1'b0}}, mag_reg} * {{VALUE_W{1'b0}}, RECIP_10};
    assign quot    = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
    assign times10 = {quot[VALUE_W-4:0], 3'b0} + {quot[VALUE_W-2:0], 1'b0};
    assign rem     = mag_reg - times10;
    assign digit   = hex_reg ? mag_reg[3:0] : rem[3:0];
    assign rest    = hex_reg ? {4'b0, mag_reg[VALUE_W-1:4]} : quot;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                    state_next = F_CONV;
            end
            F_CONV:
            begin
                if (rest == '0)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_status.full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != F_IDLE);
        push = (state_reg == F_PUSH) && !q_status.full;
        job.digits = digits_reg;
        job.nd     = nd_reg;
        job.neg    = neg_reg;
        job.pad    = pad_reg;
        job.zp     = zp_reg;
    end

    always_comb
    begin
        mag_next    = mag_reg;
        hex_next    = hex_reg;
        neg_next    = neg_reg;
        pad_next    = pad_reg;
        zp_next     = zp_reg;
        nd_next     = nd_reg;
        digits_next = digits_reg;
        case (state_reg)
            F_IDLE:
            begin
                hex_next = (fmt_op_t'(in_item.opcode) == OP_HEX);
                neg_next = (fmt_op_t'(in_item.opcode) == OP_SDEC) && in_item.value[VALUE_W-1];
                mag_next = neg_next ? (VALUE_W'(0) - in_item.value) : in_item.value;
                pad_next = (in_item.pad_width > PAD_LIMIT) ? PAD_LIMIT : in_item.pad_width;
                zp_next  = in_item.zero_pad;
                nd_next  = '0;
            end
            F_CONV:
            begin
                digits_next[nd_reg[DIGIT_IDX_W-1:0]] = digit;
                nd_next  = nd_reg + ND_W'(1);
                mag_next = rest;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        hex_reg    <= hex_next;
        neg_reg    <= neg_next;
        pad_reg    <= pad_next;
        zp_reg     <= zp_next;
        nd_reg     <= nd_next;
        digits_reg <= digits_next;
    end

endmodule

>>> sv/fmt_queue.sv
// fmt_queue: short fifo of converted jobs between front and back
// depends on fmt_pkg

module fmt_queue
    import fmt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fmt_job_t      wr_job,
    input  logic          pop,
    output fmt_job_t      head,
    output fmt_q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fmt_job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(DEPTH - 1))
            n = '0;
        else
            n = p + PTR_W'(1);
        return n;
    endfunction

    always_comb
    begin
        status.full  = (count_reg == CNT_W'(DEPTH));
        status.empty = (count_reg == '0);
        head         = mem[rd_ptr_reg];
        wr_ptr_next  = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next  = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next   = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_job;
    end

endmodule

>>> sv/fmt_back.sv
// fmt_back: emits pad, sign and digits of one job per character, registered output
// depends on fmt_pkg; reads the head of fmt_queue

module fmt_back
    import fmt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  fmt_job_t      head,
    input  fmt_q_status_t q_status,
    output logic          pop,
    output logic          strobe,
    output fmt_out_t      result
);

    fmt_back_state_t state_reg, state_next;

    fmt_job_t         job_reg, job_next;
    logic [PAD_W-1:0] pad_cnt_reg, pad_cnt_next;
    logic [ND_W-1:0]  idx_reg, idx_next;
    logic             strobe_reg, strobe_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;

    logic [PAD_W-1:0] head_len;
    logic [PAD_W-1:0] head_pad_cnt;

    assign head_len     = PAD_W'(head.nd) + PAD_W'(head.neg);
    assign head_pad_cnt = (head.pad > head_len) ? (head.pad - head_len) : '0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    if (head_pad_cnt != '0)
                        state_next = B_PAD;
                    else if (head.neg)
                        state_next = B_SIGN;
                    else
                        state_next = B_DIGIT;
                end
            end
            B_PAD:
            begin
                if (pad_cnt_reg == PAD_W'(1))
                    state_next = job_reg.neg ? B_SIGN : B_DIGIT;
            end
            B_SIGN:  state_next = B_DIGIT;
            B_DIGIT:
            begin
                if (idx_reg == '0)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop          = 1'b0;
        job_next     = job_reg;
        pad_cnt_next = pad_cnt_reg;
        idx_next     = idx_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop          = 1'b1;
                    job_next     = head;
                    pad_cnt_next = head_pad_cnt;
                    idx_next     = head.nd - ND_W'(1);
                end
            end
            B_PAD:
            begin
                strobe_next  = 1'b1;
                char_next    = job_reg.zp ? CH_ZERO : CH_SPACE;
                pad_cnt_next = pad_cnt_reg - PAD_W'(1);
            end
            B_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = CH_MINUS;
            end
            B_DIGIT:
            begin
                strobe_next = 1'b1;
                char_next   = digit_to_ascii(job_reg.digits[idx_reg[DIGIT_IDX_W-1:0]]);
                last_next   = (idx_reg == '0);
                idx_next    = idx_reg - ND_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign strobe          = strobe_reg;
    assign result.char_out = char_reg;
    assign result.last     = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        pad_cnt_reg <= pad_cnt_next;
        idx_reg     <= idx_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

endmodule

>>> sv/int_to_ascii_formatter.sv
// int_to_ascii_formatter: top level, front converter, job queue and character emitter
// depends on fmt_pkg, fmt_front, fmt_queue, fmt_back

// An item is taken when start is high and busy is low. The front end extracts the
// digits one at a time (a shared multiply by the reciprocal of ten, or a nibble
// shift for hex), then hands the job to the queue; busy stays high from the
// transfer until that hand-over, and longer while the job queue is full. The back
// end emits one character per cycle, pad first, then the sign, then digits most
// significant first, with last on the final one, and returns to idle between jobs
// to load the next. Sustained rate is set by the slower of the two. Characters
// appear for exactly one cycle with strobe high and must be taken then; nothing
// holds them.

module int_to_ascii_formatter
    import fmt_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  fmt_in_t  in_item,
    output logic     busy,
    output logic     strobe,
    output fmt_out_t result
);

    fmt_q_status_t q_status;
    fmt_job_t      push_job;
    fmt_job_t      head_job;
    logic          q_push;
    logic          q_pop;

    fmt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .in_item  (in_item),
        .busy     (busy),
        .q_status (q_status),
        .push     (q_push),
        .job      (push_job)
    );

    fmt_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_job (push_job),
        .pop    (q_pop),
        .head   (head_job),
        .status (q_status)
    );

    fmt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head_job),
        .q_status (q_status),
        .pop      (q_pop),
        .strobe   (strobe),
        .result   (result)
    );

    // an accepted item keeps the front end occupied on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // a job load cycle always separates two items' characters
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> !strobe)
        else $error("character right after last");

endmodule
